FILE: rtl/core/repeating_timer_event_table_assert.svh
// Assertion macros for the repeating timer event table.
`ifndef REPEATING_TIMER_EVENT_TABLE_ASSERT_SVH
`define REPEATING_TIMER_EVENT_TABLE_ASSERT_SVH
`ifndef SYNTHESIS
`define RTET_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define RTET_ASSERT_NR(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RTET_ASSERT(label, clk, rst, prop, msg)
`define RTET_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

FILE: rtl/core/rtet_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Repeating timer event table package
// Shared types and constants for the timer table.
// ----------------------------------------------------------------------------
package rtet_pkg;
   localparam int TABLE_DEPTH_DEFAULT = 16;
   localparam logic [62:0] WAIT_CAP = 63'h7FFF_FFFF_FFFF_FFFF;

   typedef enum logic [1:0] {
      KIND_FIRED   = 2'd0,
      KIND_SUMMARY = 2'd1,
      KIND_ACK     = 2'd2
   } kind_type;

   typedef enum logic {
      ACT_ADD  = 1'b0,
      ACT_POLL = 1'b1
   } action_type;

   // One input word.
   typedef struct packed {
      logic        action;
      logic [63:0] now;
      logic [31:0] first_delay;
      logic [31:0] period;
      logic [15:0] repeat_count;
      logic [15:0] event_tag;
   } req_type;

   // One result word.
   typedef struct packed {
      kind_type    kind;
      logic [15:0] fired_tag;
      logic [62:0] next_wait;
      logic        rejected;
      logic        last;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_SUMMARY
   } state_type;
endpackage

FILE: rtl/core/rtet_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timer table channel interfaces
// Valid/ready channels for request and response words.
// ----------------------------------------------------------------------------
interface rtet_req_if;
   logic               valid;
   logic               ready;
   rtet_pkg::req_type  payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface rtet_rsp_if;
   logic               valid;
   logic               ready;
   rtet_pkg::rsp_type  payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

FILE: rtl/core/rtet_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timer table front end
// Accepts request words into a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module rtet_front (
   input  logic              clock,
   input  logic              reset,
   rtet_req_if.sink          req,
   output logic              q_valid,
   output rtet_pkg::req_type q_word,
   input  logic              q_pop
);
   `include "repeating_timer_event_table_assert.svh"

   rtet_pkg::req_type slot_ff [2];
   logic       wr_ff, wr_in, rd_ff, rd_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push;

   // Queue control.
   assign req.ready = (cnt_ff != 2'd2);
   assign push      = req.valid && req.ready;
   assign q_valid   = (cnt_ff != 2'd0);
   assign q_word    = slot_ff[rd_ff];

   always_comb begin
      wr_in  = push ? ~wr_ff : wr_ff;
      rd_in  = q_pop ? ~rd_ff : rd_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, q_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // Payload storage.
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= req.payload;
      end
   end

   `RTET_ASSERT(a_no_pop_empty, clock, reset, q_pop |-> q_valid, "pop from empty queue")
   `RTET_ASSERT(a_cnt_max, clock, reset, cnt_ff != 2'd3, "queue count overflow")
   `RTET_ASSERT(a_ptr_cons, clock, reset,
      (cnt_ff == 2'd1) |-> (wr_ff != rd_ff), "queue pointers disagree")
endmodule

FILE: rtl/core/rtet_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timer table back end
// Holds the event table; walks it one entry per cycle on a poll unless rsp stalls.
// ----------------------------------------------------------------------------
module rtet_back #(
   parameter int TABLE_DEPTH = rtet_pkg::TABLE_DEPTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   input  rtet_pkg::req_type q_word,
   output logic              q_pop,
   rtet_rsp_if.source        rsp
);
   `include "repeating_timer_event_table_assert.svh"

   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

   // Table entries, compacted by shifting on removal.
   logic [63:0] dl_ff  [TABLE_DEPTH];
   logic [31:0] iv_ff  [TABLE_DEPTH];
   logic [15:0] rp_ff  [TABLE_DEPTH];
   logic [15:0] tg_ff  [TABLE_DEPTH];

   rtet_pkg::state_type st_ff, st_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [62:0]   best_ff, best_in;
   logic          ov_ff, ov_in;
   rtet_pkg::rsp_type ov_word_ff, ov_word_in;

   logic [IW-1:0] ix;
   logic          hit, drop, keep_going;
   logic [63:0]   new_dl, delta;
   logic [15:0]   dec_rp;
   logic          add_we, walk_we;

   assign rsp.valid   = ov_ff;
   assign rsp.payload = ov_word_ff;

   assign ix     = idx_ff[IW-1:0];
   assign hit    = dl_ff[ix] < q_word.now;
   assign new_dl = q_word.now + {32'd0, iv_ff[ix]};
   assign dec_rp = rp_ff[ix] - 16'd1;
   assign drop   = hit && (rp_ff[ix] == 16'd1);
   // A fired entry re-arms to now plus its interval, so its distance is the interval.
   assign delta  = hit ? {32'd0, iv_ff[ix]} : (dl_ff[ix] - q_word.now);

   // Sequencer: one entry per cycle unless stalled, a result register at the output.
   always_comb begin
      st_in      = st_ff;
      cnt_in     = cnt_ff;
      idx_in     = idx_ff;
      best_in    = best_ff;
      ov_in      = ov_ff && !rsp.ready;
      ov_word_in = ov_word_ff;
      q_pop      = 1'b0;
      add_we     = 1'b0;
      walk_we    = 1'b0;
      keep_going = !ov_ff || rsp.ready;
      unique case (st_ff)
         rtet_pkg::ST_IDLE: begin
            if (q_valid && keep_going) begin
               if (q_word.action == rtet_pkg::ACT_ADD) begin
                  ov_in                = 1'b1;
                  ov_word_in           = '0;
                  ov_word_in.kind      = rtet_pkg::KIND_ACK;
                  ov_word_in.last      = 1'b1;
                  ov_word_in.rejected  = (cnt_ff >= CW'(TABLE_DEPTH));
                  add_we               = !ov_word_in.rejected;
                  if (add_we) begin
                     cnt_in = cnt_ff + CW'(1);
                  end
                  q_pop = 1'b1;
               end else begin
                  idx_in  = '0;
                  best_in = rtet_pkg::WAIT_CAP;
                  st_in   = rtet_pkg::ST_WALK;
               end
            end
         end
         rtet_pkg::ST_WALK: begin
            if (idx_ff >= cnt_ff) begin
               st_in = rtet_pkg::ST_SUMMARY;
            end else if (keep_going) begin
               walk_we = 1'b1;
               if (hit) begin
                  ov_in                = 1'b1;
                  ov_word_in           = '0;
                  ov_word_in.kind      = rtet_pkg::KIND_FIRED;
                  ov_word_in.fired_tag = tg_ff[ix];
               end
               if (drop) begin
                  cnt_in = cnt_ff - CW'(1);
               end else begin
                  idx_in = idx_ff + CW'(1);
                  if (delta[63] == 1'b0 && delta[62:0] < best_ff) begin
                     best_in = delta[62:0];
                  end
               end
            end
         end
         rtet_pkg::ST_SUMMARY: begin
            if (keep_going) begin
               ov_in                = 1'b1;
               ov_word_in           = '0;
               ov_word_in.kind      = rtet_pkg::KIND_SUMMARY;
               ov_word_in.next_wait = best_ff;
               ov_word_in.last      = 1'b1;
               q_pop                = 1'b1;
               st_in                = rtet_pkg::ST_IDLE;
            end
         end
         default: st_in = rtet_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff  <= rtet_pkg::ST_IDLE;
         cnt_ff <= '0;
         ov_ff  <= 1'b0;
      end else begin
         st_ff  <= st_in;
         cnt_ff <= cnt_in;
         ov_ff  <= ov_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff     <= idx_in;
      best_ff    <= best_in;
      ov_word_ff <= ov_word_in;
   end

   // Table update: append on add, re-arm or shift up on a walk step.
   always_ff @(posedge clock) begin
      for (int j = 0; j < TABLE_DEPTH; j++) begin
         if (add_we && cnt_ff == CW'(j)) begin
            dl_ff[j] <= q_word.now + {32'd0, q_word.first_delay};
            iv_ff[j] <= q_word.period;
            rp_ff[j] <= q_word.repeat_count;
            tg_ff[j] <= q_word.event_tag;
         end else if (walk_we && drop && CW'(j) >= idx_ff && j + 1 < TABLE_DEPTH) begin
            dl_ff[j] <= dl_ff[j + 1];
            iv_ff[j] <= iv_ff[j + 1];
            rp_ff[j] <= rp_ff[j + 1];
            tg_ff[j] <= tg_ff[j + 1];
         end else if (walk_we && hit && !drop && idx_ff == CW'(j)) begin
            dl_ff[j] <= new_dl;
            if (rp_ff[j] != 16'd0) begin
               rp_ff[j] <= dec_rp;
            end
         end
      end
   end

   `RTET_ASSERT(a_cnt_range, clock, reset, cnt_ff <= CW'(TABLE_DEPTH), "entry count out of range")
   `RTET_ASSERT(a_hold, clock, reset,
      (rsp.valid && !rsp.ready) |=> (rsp.valid && $stable(rsp.payload)),
      "result changed while stalled")
   `RTET_ASSERT(a_idle_pop, clock, reset,
      (q_pop && st_ff == rtet_pkg::ST_WALK) |-> 1'b0, "pop during walk")
   `RTET_ASSERT(a_summary_last, clock, reset,
      (rsp.valid && rsp.payload.kind == rtet_pkg::KIND_SUMMARY) |-> rsp.payload.last,
      "summary without last")
endmodule

FILE: rtl/core/repeating_timer_event_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Repeating timer event table
// Timer events in insertion order; polls fire expired events and report wait.
// ----------------------------------------------------------------------------
//  channel | dir | contents
//  req     | in  | action, now, first_delay, period, repeat_count, event_tag
//  rsp     | out | kind, fired_tag, next_wait, rejected, last
//
// An add is acknowledged from the result register as it leaves the queue.
// A poll walks the table, the back end visiting one entry a cycle while the
// result register is not stalled, and then presents the summary; a removed
// entry takes a walk step like any other.
// Reset is synchronous and empties the table; no clearing pass is needed.
// A stalled result holds the walk; the front queue accepts until it is full.
module repeating_timer_event_table #(
   parameter int TABLE_DEPTH = rtet_pkg::TABLE_DEPTH_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   rtet_req_if.sink   req,
   rtet_rsp_if.source rsp
);
   logic              q_valid;
   logic              q_pop;
   rtet_pkg::req_type q_word;

   rtet_front u_front (
      .clock   (clock),
      .reset   (reset),
      .req     (req),
      .q_valid (q_valid),
      .q_word  (q_word),
      .q_pop   (q_pop)
   );

   rtet_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
      .clock   (clock),
      .reset   (reset),
      .q_valid (q_valid),
      .q_word  (q_word),
      .q_pop   (q_pop),
      .rsp     (rsp)
   );
endmodule
